// File: rtl/kmd_pkg.sv
// kmd_pkg: shared types and constants for the key matrix debounce block
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  localparam int unsigned CntW = 8;

  localparam logic [CntW-1:0] DebounceReset = 8'd5;

  typedef struct packed {
    logic load;
    logic copy;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/kmd_lane.sv
// kmd_lane: one row lane, holds the sample and stable row and flags a change
`timescale 1ns / 1ps
`default_nettype none

module kmd_lane #(
  parameter int unsigned COLS = 21
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COLS-1:0]    columns_n_i,
  input  wire kmd_pkg::lane_ctrl_t ctrl_i,
  output logic                    differ_o,
  output logic [COLS-1:0]         stable_o
);

  logic [COLS-1:0] sample_q, sample_d;
  logic [COLS-1:0] stable_q;

  // pressed keys read high
  assign sample_d = ~columns_n_i;
  assign differ_o = (sample_d != sample_q);
  assign stable_o = stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      stable_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        sample_q <= sample_d;
      end
      if (ctrl_i.load && ctrl_i.copy) begin
        stable_q <= sample_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/kmd_merge.sv
// kmd_merge: combines lane change flags, runs the shared settle counter
`timescale 1ns / 1ps
`default_nettype none

module kmd_merge #(
  parameter int unsigned ROWS = 5
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [ROWS-1:0]           differ_i,
  input  wire logic [kmd_pkg::CntW-1:0]  debounce_i,
  output kmd_pkg::lane_ctrl_t            ctrl_o,
  output logic [kmd_pkg::CntW-1:0]       settle_o,
  output logic                           changed_o
);

  logic [kmd_pkg::CntW-1:0] cnt_q, cnt_d, cnt_mid;
  logic                     changed_q;
  logic                     any_diff;
  logic                     copy;

  assign any_diff = |differ_i;

  always_comb begin
    cnt_mid = any_diff ? debounce_i : cnt_q;
    cnt_d   = cnt_mid;
    copy    = 1'b0;
    if (cnt_mid != '0) begin
      cnt_d = cnt_mid - kmd_pkg::CntW'(1);
      copy  = (cnt_d == '0);
    end
  end

  assign ctrl_o.load = accept_i;
  assign ctrl_o.copy = copy;
  assign settle_o    = cnt_q;
  assign changed_o   = changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= kmd_pkg::DebounceReset;
      changed_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q     <= cnt_d;
      changed_q <= any_diff;
    end
  end

endmodule

`default_nettype wire

// File: rtl/key_matrix_debounce.sv
// key_matrix_debounce: top level, row lanes, merge stage and output register
//
// channel   direction  content
// s_axis    in         one scan pass: active-low column lines of every row
// m_axis    out        stable rows, settle counter, sample change flag
// cfg       in         debounce scan count, written when cfg_wr_en_i is high
//
// one word per cycle; a word is taken whenever the output register is empty
// or being drained, the result appears in the cycle after acceptance
// the compare, counter update and row copy all finish in the accepting cycle
// reset clears samples and stable rows, loads counter and count with 5
// a stalled m_axis holds its word and s_axis_tready_o drops
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debounce #(
  parameter int unsigned ROWS = 5,
  parameter int unsigned COLS = 21
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // row0_columns_n, row1_columns_n, ... (COLS bits each), zero padded
  input  wire logic [((ROWS * COLS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  // row0_stable, row1_stable, ... (COLS bits each), settle_left, sample_changed
  output logic [((ROWS * COLS + kmd_pkg::CntW + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  input  wire logic                     cfg_wr_en_i,
  input  wire logic [kmd_pkg::CntW-1:0] cfg_wr_data_i
);

  localparam int unsigned MatW = ROWS * COLS;

  logic                      accept;
  logic                      m_valid_q, m_valid_d;
  logic [kmd_pkg::CntW-1:0]  debounce_q;
  logic [ROWS-1:0]           differ;
  logic [COLS-1:0]           stable [ROWS];
  kmd_pkg::lane_ctrl_t       ctrl;
  logic [kmd_pkg::CntW-1:0]  settle;
  logic                      changed;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_valid_d       = accept || (m_valid_q && !m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      debounce_q <= kmd_pkg::DebounceReset;
    end else begin
      m_valid_q <= m_valid_d;
      if (cfg_wr_en_i) begin
        debounce_q <= cfg_wr_data_i;
      end
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    kmd_lane #(
      .COLS(COLS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .columns_n_i(s_axis_tdata_i[r*COLS +: COLS]),
      .ctrl_i     (ctrl),
      .differ_o   (differ[r]),
      .stable_o   (stable[r])
    );
  end

  kmd_merge #(
    .ROWS(ROWS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .differ_i  (differ),
    .debounce_i(debounce_q),
    .ctrl_o    (ctrl),
    .settle_o  (settle),
    .changed_o (changed)
  );

  // state only moves on acceptance, so it always matches the held word
  always_comb begin
    m_axis_tdata_o = '0;
    for (int r = 0; r < ROWS; r++) begin
      m_axis_tdata_o[r*COLS +: COLS] = stable[r];
    end
    m_axis_tdata_o[MatW +: kmd_pkg::CntW] = settle;
    m_axis_tdata_o[MatW + kmd_pkg::CntW]  = changed;
  end

endmodule

`default_nettype wire
